FILE: rtl/dlps_pkg.sv
package dlps_pkg;

   localparam int TableDepthDefault = 1024;
   localparam int KeyCharsDefault = 5;
   localparam int WordBits = 40;
   localparam int SlotBits = 10;
   localparam int HashStart = 5381;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   typedef struct packed {
      op_type op;
      logic [WordBits-1:0] word;
   } req_word_type;

   typedef struct packed {
      logic found;
      logic [SlotBits-1:0] slot;
      status_type status;
   } rsp_word_type;

   // Number of conditional subtractions of depth<<k that bring 33*r+byte below depth.
   function automatic int mod_steps(input int depth);
      int steps;
      steps = 0;
      while ((depth << steps) <= 33 * depth + 255) begin
         steps++;
      end
      return steps;
   endfunction

endpackage

FILE: rtl/dlps_stream_if.sv
interface dlps_stream_if #(parameter type word_type = logic) ();
   logic valid;
   logic ready;
   word_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/dlps_hash.sv
module dlps_hash #(
   parameter int TABLE_DEPTH = dlps_pkg::TableDepthDefault,
   parameter int KEY_CHARS = dlps_pkg::KeyCharsDefault,
   localparam int IdxBits = $clog2(TABLE_DEPTH),
   localparam int KeyBits = KEY_CHARS * 8
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [dlps_pkg::WordBits-1:0] word,
   output logic done,
   output logic [IdxBits-1:0] home,
   output logic [KeyBits-1:0] key
);

   localparam int SumBits = $clog2(33 * TABLE_DEPTH + 256);
   localparam int Steps = dlps_pkg::mod_steps(TABLE_DEPTH);
   localparam int StartMod = dlps_pkg::HashStart % TABLE_DEPTH;
   localparam int CntBits = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;

   logic busy_ff;
   logic done_ff;
   logic [CntBits-1:0] cnt_ff;
   logic [KeyBits-1:0] shift_ff;
   logic [KeyBits-1:0] key_ff;
   logic [IdxBits-1:0] rem_ff;

   logic [7:0] cur_byte;
   logic byte_zero;
   logic byte_last;
   logic [SumBits-1:0] sum;
   logic [SumBits-1:0] red;
   logic [IdxBits-1:0] rem_in;

   assign cur_byte = shift_ff[KeyBits-1 -: 8];
   assign byte_zero = (cur_byte == 8'd0);
   assign byte_last = (cnt_ff == CntBits'(KEY_CHARS - 1));

   // The remainder is carried through the hash, so the full hash is never formed.
   always_comb begin
      sum = (SumBits'(rem_ff) << 5) + SumBits'(rem_ff) + SumBits'(cur_byte);
      red = sum;
      for (int k = Steps - 1; k >= 0; k--) begin
         if (red >= SumBits'(TABLE_DEPTH << k)) begin
            red = red - SumBits'(TABLE_DEPTH << k);
         end
      end
      rem_in = IdxBits'(red);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (byte_zero || byte_last) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // The key gathers the bytes before the first zero byte, right aligned.
   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         shift_ff <= KeyBits'(word);
         key_ff <= '0;
         rem_ff <= IdxBits'(StartMod);
      end else if (busy_ff && !byte_zero) begin
         cnt_ff <= cnt_ff + 1'b1;
         shift_ff <= shift_ff << 8;
         key_ff <= (key_ff << 8) | KeyBits'(cur_byte);
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign home = rem_ff;
   assign key = key_ff;

endmodule

FILE: rtl/dlps_ram.sv
module dlps_ram #(
   parameter int Depth = dlps_pkg::TableDepthDefault,
   parameter int Width = dlps_pkg::KeyCharsDefault * 8 + 1,
   localparam int AddrBits = $clog2(Depth)
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/djb2_linear_probe_set.sv
// Open-addressed hash set of short words with linear probing.
// The req channel carries one word per item: op (insert or lookup) and a
// zero-padded word of up to KEY_CHARS bytes. The rsp channel returns one
// word per item: found, slot and status, with status marking a full table
// on insert. Both channels use valid/ready; a word moves when both are high.
// The home slot is the djb2 hash of the word modulo TABLE_DEPTH, worked out
// one byte per cycle with the remainder carried along. The table lives in
// one memory with a registered read, probed one slot per cycle. One item
// is in work at a time: req is ready again once the response is loaded
// into the output register, so a new word is taken only after the last one
// is finished. After reset every slot is marked free by a sweep over all
// TABLE_DEPTH slots, during which req is not ready. The response sits in
// an output register; while rsp is stalled a new word is still accepted
// and worked on, and the finished result waits in the last probe until the
// register frees up.
module djb2_linear_probe_set #(
   parameter int TABLE_DEPTH = dlps_pkg::TableDepthDefault,
   parameter int KEY_CHARS = dlps_pkg::KeyCharsDefault
) (
   input logic clock,
   input logic reset,
   dlps_stream_if.sink req_if,
   dlps_stream_if.source rsp_if
);

   localparam int IdxBits = $clog2(TABLE_DEPTH);
   localparam int KeyBits = KEY_CHARS * 8;
   localparam int EntryBits = KeyBits + 1;
   localparam int SlotW = dlps_pkg::SlotBits;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_HASH  = 4'b0100,
      S_PROBE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [IdxBits-1:0] clr_ff, clr_in;
   logic [IdxBits-1:0] idx_ff, idx_in;
   logic [IdxBits-1:0] n_ff, n_in;
   dlps_pkg::op_type op_ff, op_in;
   logic rsp_valid_ff, rsp_valid_in;
   dlps_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic hash_start;
   logic hash_done;
   logic [IdxBits-1:0] hash_home;
   logic [KeyBits-1:0] hash_key;

   logic wr_en;
   logic [IdxBits-1:0] wr_addr;
   logic [EntryBits-1:0] wr_data;
   logic rd_en;
   logic [IdxBits-1:0] rd_addr;
   logic [EntryBits-1:0] rd_data;

   logic rsp_free;
   logic entry_used;
   logic entry_match;
   logic probe_last;
   logic [IdxBits-1:0] idx_next;
   logic finish;
   logic write_slot;
   dlps_pkg::rsp_word_type result;

   dlps_hash #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_CHARS(KEY_CHARS)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .word(req_if.data.word),
      .done(hash_done),
      .home(hash_home),
      .key(hash_key)
   );

   dlps_ram #(
      .Depth(TABLE_DEPTH),
      .Width(EntryBits)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign entry_used = rd_data[KeyBits];
   assign entry_match = (rd_data[KeyBits-1:0] == hash_key);
   assign probe_last = (n_ff == IdxBits'(TABLE_DEPTH - 1));
   assign idx_next = (idx_ff == IdxBits'(TABLE_DEPTH - 1)) ? '0 : idx_ff + 1'b1;

   // Outcome of the slot whose entry was last read from the table.
   always_comb begin
      finish = 1'b0;
      write_slot = 1'b0;
      result.found = 1'b0;
      result.slot = '0;
      result.status = dlps_pkg::STATUS_OK;
      if (op_ff == dlps_pkg::OP_INSERT) begin
         if (!entry_used) begin
            finish = 1'b1;
            write_slot = 1'b1;
            result.found = 1'b1;
            result.slot = SlotW'(idx_ff);
         end else if (probe_last) begin
            finish = 1'b1;
            result.status = dlps_pkg::STATUS_FULL;
         end
      end else begin
         if (!entry_used) begin
            finish = 1'b1;
         end else if (entry_match) begin
            finish = 1'b1;
            result.found = 1'b1;
            result.slot = SlotW'(idx_ff);
         end else if (probe_last) begin
            finish = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      op_in = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in = rsp_data_ff;
      hash_start = 1'b0;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = {1'b1, hash_key};
      rd_en = 1'b0;
      rd_addr = idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IdxBits'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               hash_start = 1'b1;
               op_in = req_if.data.op;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               rd_en = 1'b1;
               rd_addr = hash_home;
               idx_in = hash_home;
               n_in = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (finish) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = result;
                  wr_en = write_slot;
                  state_in = S_IDLE;
               end
            end else begin
               rd_en = 1'b1;
               rd_addr = idx_next;
               idx_in = idx_next;
               n_in = n_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      n_ff <= n_in;
      op_ff <= op_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data = rsp_data_ff;

endmodule

FILE: rtl/dlps_checker.sv
module dlps_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input dlps_pkg::rsp_word_type rsp_data
);

   // The table sweep after reset keeps the input closed.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req ready in the cycle after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.slot == '0)
      else $error("slot not zero on a miss");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == dlps_pkg::STATUS_FULL |-> !rsp_data.found)
      else $error("full table reported together with found");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word dropped or changed while stalled");

endmodule

bind djb2_linear_probe_set dlps_checker u_dlps_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_data(rsp_if.data)
);

FILE: dv/djb2_linear_probe_set_test.sv
`timescale 1ns / 100ps

class probe_set_tracker;
   localparam int Depth = dlps_pkg::TableDepthDefault;
   localparam int Chars = dlps_pkg::KeyCharsDefault;
   localparam int ReportLimit = 10;

   bit slot_taken [Depth];
   logic [dlps_pkg::WordBits-1:0] slot_key [Depth];
   dlps_pkg::rsp_word_type awaited [$];
   int taken_count;
   int mismatches;

   function new();
      taken_count = 0;
      mismatches = 0;
   endfunction

   // The key keeps only the bytes before the first zero byte.
   function void cut_word(input logic [dlps_pkg::WordBits-1:0] w,
                          output logic [dlps_pkg::WordBits-1:0] key, output int home);
      logic [63:0] h;
      logic [7:0] c;
      bit ended;
      h = 64'(dlps_pkg::HashStart);
      key = '0;
      ended = 1'b0;
      for (int i = 0; i < Chars; i++) begin
         c = w[(Chars-1-i)*8 +: 8];
         if (c == 8'd0) ended = 1'b1;
         if (!ended) begin
            h = h * 33 + 64'(c);
            key[(Chars-1-i)*8 +: 8] = c;
         end
      end
      home = int'(h % 64'(Depth));
   endfunction

   function void record_request(dlps_pkg::req_word_type req);
      logic [dlps_pkg::WordBits-1:0] key;
      int idx;
      bit done;
      dlps_pkg::rsp_word_type want;
      cut_word(req.word, key, idx);
      want.found = 1'b0;
      want.slot = '0;
      want.status = dlps_pkg::STATUS_OK;
      done = 1'b0;
      if (req.op == dlps_pkg::OP_INSERT) begin
         want.status = dlps_pkg::STATUS_FULL;
         for (int n = 0; n < Depth && !done; n++) begin
            if (!slot_taken[idx]) begin
               slot_taken[idx] = 1'b1;
               slot_key[idx] = key;
               taken_count++;
               want.found = 1'b1;
               want.slot = idx[dlps_pkg::SlotBits-1:0];
               want.status = dlps_pkg::STATUS_OK;
               done = 1'b1;
            end else begin
               idx = (idx + 1) % Depth;
            end
         end
      end else begin
         for (int n = 0; n < Depth && !done; n++) begin
            if (!slot_taken[idx]) begin
               done = 1'b1;
            end else if (slot_key[idx] == key) begin
               want.found = 1'b1;
               want.slot = idx[dlps_pkg::SlotBits-1:0];
               done = 1'b1;
            end else begin
               idx = (idx + 1) % Depth;
            end
         end
      end
      awaited.push_back(want);
   endfunction

   function void complain(string what, int want, int got);
      mismatches++;
      if (mismatches <= ReportLimit) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   function void check_reply(dlps_pkg::rsp_word_type got);
      dlps_pkg::rsp_word_type want;
      if (awaited.size() == 0) begin
         complain("response with no request outstanding, slot", -1, int'(got.slot));
      end else begin
         want = awaited.pop_front();
         if (got.found !== want.found) complain("found", int'(want.found), int'(got.found));
         if (got.slot !== want.slot) complain("slot", int'(want.slot), int'(got.slot));
         if (got.status !== want.status) begin
            complain("status", int'(want.status), int'(got.status));
         end
      end
   endfunction
endclass

module djb2_linear_probe_set_test;

   localparam int TableDepth = dlps_pkg::TableDepthDefault;
   localparam int KeyChars = dlps_pkg::KeyCharsDefault;
   localparam int WordBits = dlps_pkg::WordBits;
   localparam int PoolSize = 48;

   logic clock;
   logic reset;
   bit sender_pauses;
   bit receiver_stalls;
   probe_set_tracker tracker;
   logic [WordBits-1:0] word_pool [PoolSize];
   logic [WordBits-1:0] kept_words [$];

   dlps_stream_if #(.word_type(dlps_pkg::req_word_type)) req_if ();
   dlps_stream_if #(.word_type(dlps_pkg::rsp_word_type)) rsp_if ();

   djb2_linear_probe_set u_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (req_if.valid && req_if.ready) tracker.record_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) tracker.check_reply(rsp_if.data);
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // Word: random bytes, a zero byte if short, then zeros or leftovers.
   function automatic logic [WordBits-1:0] make_word();
      logic [WordBits-1:0] w;
      int len;
      bit leftover;
      w = '0;
      len = $urandom_range(0, KeyChars);
      leftover = $urandom_range(0, 1);
      for (int i = 0; i < KeyChars; i++) begin
         if (i < len) w[(KeyChars-1-i)*8 +: 8] = 8'($urandom_range(1, 255));
         else if (i > len && leftover) w[(KeyChars-1-i)*8 +: 8] = 8'($urandom);
      end
      return w;
   endfunction

   function automatic logic [WordBits-1:0] fresh_word();
      if ($urandom_range(0, 9) < 3) return make_word();
      return {8'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [WordBits-1:0] insert_word();
      if ($urandom_range(0, 9) < 7) return fresh_word();
      return word_pool[$urandom_range(0, PoolSize - 1)];
   endfunction

   function automatic logic [WordBits-1:0] lookup_word();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick < 2 && kept_words.size() != 0) begin
         return kept_words[$urandom_range(0, kept_words.size() - 1)];
      end
      if (pick == 2) return word_pool[$urandom_range(0, PoolSize - 1)];
      return fresh_word();
   endfunction

   task automatic send_word(input dlps_pkg::op_type op, input logic [WordBits-1:0] w);
      dlps_pkg::req_word_type item;
      if (sender_pauses && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      item.op = op;
      item.word = w;
      req_if.valid <= 1'b1;
      req_if.data <= item;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
      if (op == dlps_pkg::OP_INSERT) kept_words.push_back(w);
   endtask

   task automatic send_mixed(input int insert_percent);
      if ($urandom_range(0, 99) < insert_percent) begin
         send_word(dlps_pkg::OP_INSERT, insert_word());
      end else begin
         send_word(dlps_pkg::OP_LOOKUP, lookup_word());
      end
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      sender_pauses = 1'b0;
      receiver_stalls = 1'b0;
      for (int i = 0; i < PoolSize; i++) word_pool[i] = make_word();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(dlps_pkg::OP_LOOKUP, 40'h6162630000);
      send_word(dlps_pkg::OP_INSERT, 40'h0000000000);
      send_word(dlps_pkg::OP_LOOKUP, 40'h0041424344);
      send_word(dlps_pkg::OP_INSERT, 40'hFFFFFFFFFF);
      send_word(dlps_pkg::OP_INSERT, 40'h0101010101);
      send_word(dlps_pkg::OP_INSERT, 40'h616263007F);
      send_word(dlps_pkg::OP_LOOKUP, 40'h6162630000);
      send_word(dlps_pkg::OP_INSERT, 40'h6162630000);
      send_word(dlps_pkg::OP_LOOKUP, 40'h61626300FF);
      send_word(dlps_pkg::OP_LOOKUP, 40'hFFFFFFFFFF);
      send_word(dlps_pkg::OP_LOOKUP, 40'h0101010101);
      send_word(dlps_pkg::OP_LOOKUP, 40'h0101010100);
      send_word(dlps_pkg::OP_INSERT, 40'h8000000000);
      send_word(dlps_pkg::OP_LOOKUP, 40'h8000000001);
      send_word(dlps_pkg::OP_LOOKUP, 40'h7FFFFFFFFF);

      for (int n = 0; n < 1350; n++) begin
         if (n % 50 == 0) begin
            sender_pauses = $urandom_range(0, 2) != 0;
            receiver_stalls = $urandom_range(0, 2) != 0;
         end
         send_mixed(55);
      end

      while (tracker.taken_count < TableDepth) send_mixed(80);

      sender_pauses = 1'b0;
      receiver_stalls = 1'b0;
      for (int n = 0; n < 40; n++) begin
         if (n % 2 == 0) send_word(dlps_pkg::OP_INSERT, insert_word());
         else if (n % 4 == 1) send_word(dlps_pkg::OP_LOOKUP, fresh_word());
         else send_word(dlps_pkg::OP_LOOKUP, lookup_word());
      end
      req_if.valid <= 1'b0;

      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (TableDepth + 16) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: sim.f
rtl/dlps_pkg.sv
rtl/dlps_stream_if.sv
rtl/dlps_hash.sv
rtl/dlps_ram.sv
rtl/djb2_linear_probe_set.sv
rtl/dlps_checker.sv
dv/djb2_linear_probe_set_test.sv
